[hdl/tks_pkg.sv]
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants for the threshold top-k selector: register
// indexes, command codes, cell operations and the controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

  // Fixed field widths
  localparam int unsigned SCORE_W      = 8;
  localparam int unsigned MIN_SCORE_W  = 9;
  localparam int unsigned KEEP_COUNT_W = 10;
  localparam int unsigned CHANNELS_W   = 4;
  localparam int unsigned PICK_W       = 3;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCORE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SORTED_OUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_PICK = 3'd4;

  // Register reset values
  localparam logic [MIN_SCORE_W-1:0]  MIN_SCORE_RST    = 9'h180;
  localparam logic [KEEP_COUNT_W-1:0] KEEP_COUNT_RST   = 10'd500;
  localparam logic                    SORTED_OUT_RST   = 1'b1;
  localparam logic [CHANNELS_W-1:0]   CHANNELS_RST     = 4'd1;
  localparam logic [PICK_W-1:0]       CHANNEL_PICK_RST = 3'd0;

  // Interleave stride limits
  localparam logic [CHANNELS_W-1:0] CHANNELS_MIN = 4'd1;
  localparam logic [CHANNELS_W-1:0] CHANNELS_MAX = 4'd8;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Operation applied by every cell of the chain in the same cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT,
    OP_SORT
  } tks_op_t;

  // Broadcast control from the controller to the cells
  typedef struct packed {
    tks_op_t                    op;
    logic                       odd_phase;
    logic signed [SCORE_W-1:0]  new_score;
  } tks_cell_ctl_t;

  // Controller states
  typedef enum logic {
    ST_RUN,
    ST_SORT
  } tks_state_t;

endpackage

`default_nettype wire

[hdl/tks_cell.sv]
// ----------------------------------------------------------------------------
// tks_cell
// One slot of the insertion chain: holds a score and a position, compares
// against the broadcast score, and trades contents with its neighbors on
// insert, read-out shift and odd-even transposition sort passes.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_cell #(
  parameter int unsigned PW = 16
) (
  input  wire                                   clk,
  input  wire tks_pkg::tks_cell_ctl_t           ctl,
  input  wire        [PW-1:0]                   new_pos,
  input  wire                                   is_odd,
  input  wire                                   occ,
  input  wire                                   next_occ,
  input  wire                                   prev_ge,
  input  wire signed [tks_pkg::SCORE_W-1:0]     prev_score,
  input  wire        [PW-1:0]                   prev_pos,
  input  wire signed [tks_pkg::SCORE_W-1:0]     next_score,
  input  wire        [PW-1:0]                   next_pos,
  output logic                                  ge,
  output logic signed [tks_pkg::SCORE_W-1:0]    score,
  output logic       [PW-1:0]                   pos
);

  logic signed [tks_pkg::SCORE_W-1:0] score_r;
  logic signed [tks_pkg::SCORE_W-1:0] score_nxt;
  logic        [PW-1:0]               pos_r;
  logic        [PW-1:0]               pos_nxt;
  logic                               left_member;

  // Occupied and at least the incoming score: entry stays ahead of it
  assign ge          = occ && (score_r >= ctl.new_score);
  assign left_member = (is_odd == ctl.odd_phase);
  assign score       = score_r;
  assign pos         = pos_r;

  // Pick the next contents from self, new item or a neighbor
  always_comb begin
    score_nxt = score_r;
    pos_nxt   = pos_r;
    case (ctl.op)
      tks_pkg::OP_INSERT: begin
        if (!ge) begin
          if (prev_ge) begin
            score_nxt = ctl.new_score;
            pos_nxt   = new_pos;
          end else begin
            score_nxt = prev_score;
            pos_nxt   = prev_pos;
          end
        end
      end
      tks_pkg::OP_SHIFT: begin
        score_nxt = next_score;
        pos_nxt   = next_pos;
      end
      tks_pkg::OP_SORT: begin
        if (left_member) begin
          if (next_occ && (pos_r > next_pos)) begin
            score_nxt = next_score;
            pos_nxt   = next_pos;
          end
        end else begin
          if (occ && (prev_pos > pos_r)) begin
            score_nxt = prev_score;
            pos_nxt   = prev_pos;
          end
        end
      end
      default: begin
        score_nxt = score_r;
        pos_nxt   = pos_r;
      end
    endcase
  end

  // Hold the slot contents
  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    pos_r   <= pos_nxt;
  end

endmodule

`default_nettype wire

[hdl/threshold_top_k_select.sv]
// ----------------------------------------------------------------------------
// threshold_top_k_select
// Keeps the best-scoring elements of one channel of an interleaved score
// stream in a chain of insertion cells and drains them on read commands.
// ----------------------------------------------------------------------------
// A new command is accepted whenever busy is low. Each read puts one result
// on the out_ ports the cycle after the read is accepted, flagged by
// out_strobe, which is high for a single cycle; the receiver cannot stall,
// so it must take every strobed result. A push is compared against all cells
// at once and lands in its place in the chain. The push that closes a set
// with index order selected (sorted_out 0) holds busy afterward, when 2 or
// more entries are kept, while the chain runs one odd-even transposition pass
// per cycle, one pass for each kept entry.
// Reads shift the chain toward cell 0, which feeds the result registers.
// There is no clearing pass after reset.
`default_nettype none

module threshold_top_k_select #(
  parameter int unsigned MAX_KEEP      = 512,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  // Command channel
  input  wire                                        start,
  output logic                                       busy,
  input  wire                                        in_cmd,
  input  wire signed [tks_pkg::SCORE_W-1:0]          in_score,
  input  wire                                        in_final_element,
  // Result channel
  output logic                                       out_strobe,
  output logic                                       out_valid_res,
  output logic signed [tks_pkg::SCORE_W-1:0]         out_best_score,
  output logic       [POSITION_BITS-1:0]             out_position,
  output logic                                       out_end_of_list,
  // Configuration port
  input  wire                                        cfg_wr_en,
  input  wire        [tks_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire        [tks_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);

  localparam int unsigned PW = POSITION_BITS;
  localparam int unsigned CW = $clog2(MAX_KEEP + 1);
  localparam int unsigned KW = (CW > tks_pkg::KEEP_COUNT_W) ? CW : tks_pkg::KEEP_COUNT_W;

  // Configuration registers
  logic signed [tks_pkg::MIN_SCORE_W-1:0]  min_score_r;
  logic        [tks_pkg::KEEP_COUNT_W-1:0] keep_count_r;
  logic                                    sorted_out_r;
  logic        [tks_pkg::CHANNELS_W-1:0]   channels_r;
  logic        [tks_pkg::PICK_W-1:0]       channel_pick_r;

  // Set state
  tks_pkg::tks_state_t state_r, state_nxt;
  logic [KW-1:0]       sort_cnt_r, sort_cnt_nxt;
  logic [KW-1:0]       kt_r, kt_nxt;
  logic [PW-1:0]       elem_r, elem_nxt;
  logic [2:0]          phase_r, phase_nxt;
  logic                closed_r, closed_nxt;

  // Result registers
  logic                               out_strobe_r, out_strobe_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [tks_pkg::SCORE_W-1:0] out_score_r, out_score_nxt;
  logic [PW-1:0]                      out_pos_r, out_pos_nxt;
  logic                               out_eol_r, out_eol_nxt;

  // Decode
  logic                           accept;
  logic                           push;
  logic                           read;
  logic                           can_read;
  logic [tks_pkg::CHANNELS_W-1:0] eff_ch;
  logic [KW-1:0]                  keep_ext;
  logic [KW-1:0]                  limit;
  logic [KW-1:0]                  kt_base;
  logic [KW-1:0]                  kt_ins_base;
  logic [KW-1:0]                  kt_ins;
  logic [KW-1:0]                  kt_fin;
  logic [KW-1:0]                  kt_occ;
  logic [PW-1:0]                  elem_base;
  logic [2:0]                     phase_base;
  logic [3:0]                     phase_inc;
  logic                           selected;
  logic                           do_insert;

  tks_pkg::tks_cell_ctl_t ctl;

  // Chain wiring
  logic                               occ      [MAX_KEEP];
  logic                               cell_ge  [MAX_KEEP];
  logic signed [tks_pkg::SCORE_W-1:0] cell_score [MAX_KEEP];
  logic        [PW-1:0]               cell_pos [MAX_KEEP];

  assign busy   = (state_r == tks_pkg::ST_SORT);
  assign accept = start && !busy;
  assign push   = accept && (in_cmd == tks_pkg::CMD_PUSH);
  assign read   = accept && (in_cmd == tks_pkg::CMD_READ);
  assign can_read = closed_r && (kt_r != '0);

  // Clamp the stride and the keep limit
  always_comb begin
    if (channels_r < tks_pkg::CHANNELS_MIN) begin
      eff_ch = tks_pkg::CHANNELS_MIN;
    end else if (channels_r > tks_pkg::CHANNELS_MAX) begin
      eff_ch = tks_pkg::CHANNELS_MAX;
    end else begin
      eff_ch = channels_r;
    end
  end

  assign keep_ext = KW'(keep_count_r);
  assign limit    = (keep_ext < KW'(MAX_KEEP)) ? keep_ext : KW'(MAX_KEEP);

  // A push after the set closed starts from an empty set
  assign kt_base     = closed_r ? '0 : kt_r;
  assign elem_base   = closed_r ? '0 : elem_r;
  assign phase_base  = closed_r ? '0 : phase_r;
  assign kt_ins_base = (kt_base > limit) ? limit : kt_base;

  assign selected  = (phase_base == channel_pick_r);
  assign do_insert = push && selected &&
                     ($signed({in_score[tks_pkg::SCORE_W-1], in_score}) >= min_score_r);
  assign phase_inc = {1'b0, phase_base} + 4'd1;

  // Count after insertion, then cut to the limit when the set closes
  assign kt_ins = do_insert ? ((kt_ins_base < limit) ? kt_ins_base + KW'(1) : kt_ins_base)
                            : kt_base;
  assign kt_fin = (in_final_element && (kt_ins > limit)) ? limit : kt_ins;
  assign kt_occ = busy ? kt_r : kt_ins_base;

  // Controller: next state and cell operation
  always_comb begin
    state_nxt     = state_r;
    sort_cnt_nxt  = sort_cnt_r;
    ctl.op        = tks_pkg::OP_HOLD;
    ctl.odd_phase = sort_cnt_r[0];
    ctl.new_score = in_score;
    case (state_r)
      tks_pkg::ST_RUN: begin
        if (push) begin
          if (do_insert) begin
            ctl.op = tks_pkg::OP_INSERT;
          end
          if (in_final_element && !sorted_out_r && (kt_fin > KW'(1))) begin
            state_nxt    = tks_pkg::ST_SORT;
            sort_cnt_nxt = kt_fin;
          end
        end else if (read && can_read) begin
          ctl.op = tks_pkg::OP_SHIFT;
        end
      end
      tks_pkg::ST_SORT: begin
        ctl.op       = tks_pkg::OP_SORT;
        sort_cnt_nxt = sort_cnt_r - KW'(1);
        if (sort_cnt_r <= KW'(1)) begin
          state_nxt = tks_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = tks_pkg::ST_RUN;
      end
    endcase
  end

  // Set bookkeeping and result capture
  always_comb begin
    kt_nxt         = kt_r;
    elem_nxt       = elem_r;
    phase_nxt      = phase_r;
    closed_nxt     = closed_r;
    out_strobe_nxt = read;
    out_valid_nxt  = out_valid_r;
    out_score_nxt  = out_score_r;
    out_pos_nxt    = out_pos_r;
    out_eol_nxt    = out_eol_r;
    if (push) begin
      kt_nxt     = kt_fin;
      elem_nxt   = selected ? elem_base + PW'(1) : elem_base;
      phase_nxt  = (phase_inc >= eff_ch) ? 3'd0 : phase_inc[2:0];
      closed_nxt = in_final_element;
    end
    if (read) begin
      out_valid_nxt = can_read;
      out_score_nxt = can_read ? cell_score[0] : '0;
      out_pos_nxt   = can_read ? cell_pos[0] : '0;
      out_eol_nxt   = can_read && (kt_r == KW'(1));
      if (can_read) begin
        kt_nxt = kt_r - KW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tks_pkg::ST_RUN;
      sort_cnt_r   <= '0;
      kt_r         <= '0;
      elem_r       <= '0;
      phase_r      <= '0;
      closed_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sort_cnt_r   <= sort_cnt_nxt;
      kt_r         <= kt_nxt;
      elem_r       <= elem_nxt;
      phase_r      <= phase_nxt;
      closed_r     <= closed_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_valid_r <= out_valid_nxt;
    out_score_r <= out_score_nxt;
    out_pos_r   <= out_pos_nxt;
    out_eol_r   <= out_eol_nxt;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_score_r    <= tks_pkg::MIN_SCORE_RST;
      keep_count_r   <= tks_pkg::KEEP_COUNT_RST;
      sorted_out_r   <= tks_pkg::SORTED_OUT_RST;
      channels_r     <= tks_pkg::CHANNELS_RST;
      channel_pick_r <= tks_pkg::CHANNEL_PICK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tks_pkg::CFG_MIN_SCORE:    min_score_r    <= cfg_wr_data[tks_pkg::MIN_SCORE_W-1:0];
        tks_pkg::CFG_KEEP_COUNT:   keep_count_r   <= cfg_wr_data[tks_pkg::KEEP_COUNT_W-1:0];
        tks_pkg::CFG_SORTED_OUT:   sorted_out_r   <= cfg_wr_data[0];
        tks_pkg::CFG_CHANNELS:     channels_r     <= cfg_wr_data[tks_pkg::CHANNELS_W-1:0];
        tks_pkg::CFG_CHANNEL_PICK: channel_pick_r <= cfg_wr_data[tks_pkg::PICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Insertion chain
  genvar i;
  generate
    for (i = 0; i < MAX_KEEP; i++) begin : g_cell
      localparam logic IS_ODD = ((i % 2) == 1);

      logic                               prev_ge;
      logic signed [tks_pkg::SCORE_W-1:0] prev_score;
      logic        [PW-1:0]               prev_pos;
      logic                               next_occ;
      logic signed [tks_pkg::SCORE_W-1:0] next_score;
      logic        [PW-1:0]               next_pos;

      assign occ[i] = (KW'(i) < kt_occ);

      if (i == 0) begin : g_first
        assign prev_ge    = 1'b1;
        assign prev_score = '0;
        assign prev_pos   = '0;
      end else begin : g_mid_prev
        assign prev_ge    = cell_ge[i-1];
        assign prev_score = cell_score[i-1];
        assign prev_pos   = cell_pos[i-1];
      end

      if (i == MAX_KEEP - 1) begin : g_last
        assign next_occ   = 1'b0;
        assign next_score = '0;
        assign next_pos   = '0;
      end else begin : g_mid_next
        assign next_occ   = occ[i+1];
        assign next_score = cell_score[i+1];
        assign next_pos   = cell_pos[i+1];
      end

      tks_cell #(
        .PW (PW)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_pos    (elem_base),
        .is_odd     (IS_ODD),
        .occ        (occ[i]),
        .next_occ   (next_occ),
        .prev_ge    (prev_ge),
        .prev_score (prev_score),
        .prev_pos   (prev_pos),
        .next_score (next_score),
        .next_pos   (next_pos),
        .ge         (cell_ge[i]),
        .score      (cell_score[i]),
        .pos        (cell_pos[i])
      );
    end
  endgenerate

  // Drive the result ports
  assign out_strobe      = out_strobe_r;
  assign out_valid_res   = out_valid_r;
  assign out_best_score  = out_score_r;
  assign out_position    = out_pos_r;
  assign out_end_of_list = out_eol_r;

endmodule

`default_nettype wire
